### rtl/binary_to_bcd_seven_segment_macros.svh
// Assertion macros shared by the binary to BCD converter checker.
`ifndef BINARY_TO_BCD_SEVEN_SEGMENT_MACROS_SVH
`define BINARY_TO_BCD_SEVEN_SEGMENT_MACROS_SVH

// Clocked assertion with an explicit disable condition.
`define B2BSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is never disabled.
`define B2BSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   `B2BSS_ASSERT(lbl, clk, 1'b0, prop, msg)

`endif

### rtl/b2bss_pkg.sv
// Package with sizes, defaults and the seven-segment encoder for the converter.
`default_nettype none
package b2bss_pkg;

   localparam int VALUE_BITS          = 32;  // width of the input value port
   localparam int OUT_DIGITS          = 8;   // digit positions on the result ports
   localparam int FULL_DIGITS         = 10;  // enough decimal digits for any 32-bit value
   localparam int BCD_BITS            = 4 * FULL_DIGITS;
   localparam int DIGIT_BITS          = 4;
   localparam int SEG_BITS            = 7;
   localparam int STEP_BITS           = 8;   // input bits handled by one pipeline stage
   localparam int INPUT_BITS_DEFAULT  = 32;
   localparam int DIGIT_COUNT_DEFAULT = 8;

   // Segment a in bit 6 down to g in bit 0
   function automatic logic [SEG_BITS-1:0] seg_encode(input logic [DIGIT_BITS-1:0] digit);
      logic [SEG_BITS-1:0] pattern;
      case (digit)
         4'd0: pattern = 7'h7E;
         4'd1: pattern = 7'h30;
         4'd2: pattern = 7'h6D;
         4'd3: pattern = 7'h79;
         4'd4: pattern = 7'h33;
         4'd5: pattern = 7'h5B;
         4'd6: pattern = 7'h5F;
         4'd7: pattern = 7'h70;
         4'd8: pattern = 7'h7F;
         4'd9: pattern = 7'h7B;
         default: pattern = '0;
      endcase
      return pattern;
   endfunction

endpackage
`default_nettype wire

### rtl/binary_to_bcd_seven_segment.sv
// Values pass through the double-dabble stages, then the segment-encoding output register.
// Throughput: one transaction per cycle while the output is not stalled; each double-dabble
// stage shifts 8 input bits and the last register stage encodes segments.
// The ready chain is combinational, so bubbles fill while the output waits and the
// input stalls only once every stage holds a transaction.
// Reset (synchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module binary_to_bcd_seven_segment
   import b2bss_pkg::*;
#(
   parameter int INPUT_BITS  = INPUT_BITS_DEFAULT,
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [VALUE_BITS-1:0]         req_binary_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [DIGIT_BITS*OUT_DIGITS-1:0]   rsp_bcd_digits,
   output logic [SEG_BITS*OUT_DIGITS-1:0]     rsp_segment_patterns,
   output logic                               rsp_overflow
);

   localparam int STAGE_COUNT = (INPUT_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS    = STAGE_COUNT * STEP_BITS;

   logic                stage_valid [0:STAGE_COUNT];
   logic                stage_ready [0:STAGE_COUNT];
   logic [BCD_BITS-1:0] stage_bcd   [0:STAGE_COUNT];
   logic [PAD_BITS-1:0] stage_bits  [0:STAGE_COUNT];

   // Pipeline entry: zero-extend the used input bits to a whole number of stages
   assign stage_valid[0] = req_valid;
   assign stage_bcd[0]   = '0;
   assign stage_bits[0]  = PAD_BITS'(req_binary_value[INPUT_BITS-1:0]);
   assign req_stall      = !stage_ready[0];

   // Double-dabble stages
   for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_stage
      b2bss_dabble_stage #(
         .PAD_BITS (PAD_BITS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_bcd   (stage_bcd[i]),
         .up_bits  (stage_bits[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_bcd   (stage_bcd[i+1]),
         .dn_bits  (stage_bits[i+1])
      );
   end

   // Segment encoding and output register
   b2bss_seg_stage #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_seg (
      .clock                (clock),
      .reset                (reset),
      .up_valid             (stage_valid[STAGE_COUNT]),
      .up_ready             (stage_ready[STAGE_COUNT]),
      .up_bcd               (stage_bcd[STAGE_COUNT]),
      .out_valid            (rsp_valid),
      .out_stall            (rsp_stall),
      .out_bcd_digits       (rsp_bcd_digits),
      .out_segment_patterns (rsp_segment_patterns),
      .out_overflow         (rsp_overflow)
   );

endmodule
`default_nettype wire

### rtl/b2bss_dabble_stage.sv
// One double-dabble pipeline stage: shifts STEP_BITS input bits into the BCD value.
`default_nettype none
module b2bss_dabble_stage
   import b2bss_pkg::*;
#(
   parameter int PAD_BITS = INPUT_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                up_valid,
   output logic                     up_ready,
   input  wire logic [BCD_BITS-1:0] up_bcd,
   input  wire logic [PAD_BITS-1:0] up_bits,
   output logic                     dn_valid,
   input  wire logic                dn_ready,
   output logic [BCD_BITS-1:0]      dn_bcd,
   output logic [PAD_BITS-1:0]      dn_bits
);

   logic                valid_ff;
   logic                valid_in;
   logic [BCD_BITS-1:0] bcd_ff;
   logic [BCD_BITS-1:0] bcd_in;
   logic [PAD_BITS-1:0] bits_ff;
   logic [PAD_BITS-1:0] bits_in;

   // Stage can load when empty or when its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_valid ? 1'b1 : (valid_ff && !dn_ready);

   // Add 3 to each digit of five or more, then shift in the next bit, MSB first
   always_comb begin
      logic [BCD_BITS-1:0] bcd_work;
      logic [PAD_BITS-1:0] bits_work;
      bcd_work  = up_bcd;
      bits_work = up_bits;
      for (int j = 0; j < STEP_BITS; j++) begin
         for (int d = 0; d < FULL_DIGITS; d++) begin
            if (bcd_work[DIGIT_BITS*d +: DIGIT_BITS] >= 4'd5) begin
               bcd_work[DIGIT_BITS*d +: DIGIT_BITS] =
                  bcd_work[DIGIT_BITS*d +: DIGIT_BITS] + 4'd3;
            end
         end
         bcd_work  = {bcd_work[BCD_BITS-2:0], bits_work[PAD_BITS-1]};
         bits_work = bits_work << 1;
      end
      bcd_in  = bcd_work;
      bits_in = bits_work;
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         bcd_ff  <= bcd_in;
         bits_ff <= bits_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_bcd   = bcd_ff;
   assign dn_bits  = bits_ff;

endmodule
`default_nettype wire

### rtl/b2bss_seg_stage.sv
// Output stage: digit masking, overflow detect and seven-segment encoding.
`default_nettype none
module b2bss_seg_stage
   import b2bss_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             up_valid,
   output logic                                  up_ready,
   input  wire logic [BCD_BITS-1:0]              up_bcd,
   output logic                                  out_valid,
   input  wire logic                             out_stall,
   output logic [DIGIT_BITS*OUT_DIGITS-1:0]      out_bcd_digits,
   output logic [SEG_BITS*OUT_DIGITS-1:0]        out_segment_patterns,
   output logic                                  out_overflow
);

   logic                                valid_ff;
   logic [DIGIT_BITS*OUT_DIGITS-1:0]    digits_ff;
   logic [DIGIT_BITS*OUT_DIGITS-1:0]    digits_in;
   logic [SEG_BITS*OUT_DIGITS-1:0]      segs_ff;
   logic [SEG_BITS*OUT_DIGITS-1:0]      segs_in;
   logic                                overflow_ff;
   logic                                overflow_in;

   // Output register frees when empty or when the transaction is taken
   assign up_ready = !valid_ff || !out_stall;

   // Keep the low DIGIT_COUNT digits; anything above means the value did not fit
   always_comb begin
      digits_in   = '0;
      segs_in     = '0;
      overflow_in = |up_bcd[BCD_BITS-1:DIGIT_BITS*DIGIT_COUNT];
      for (int k = 0; k < OUT_DIGITS; k++) begin
         if (k < DIGIT_COUNT) begin
            digits_in[DIGIT_BITS*k +: DIGIT_BITS] = up_bcd[DIGIT_BITS*k +: DIGIT_BITS];
            segs_in[SEG_BITS*k +: SEG_BITS] =
               seg_encode(up_bcd[DIGIT_BITS*k +: DIGIT_BITS]);
         end
      end
   end

   // Valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         digits_ff   <= digits_in;
         segs_ff     <= segs_in;
         overflow_ff <= overflow_in;
      end
   end

   assign out_valid            = valid_ff;
   assign out_bcd_digits       = digits_ff;
   assign out_segment_patterns = segs_ff;
   assign out_overflow         = overflow_ff;

endmodule
`default_nettype wire

### rtl/b2bss_checker.sv
// Port-level checker for the binary to BCD converter, bound to the top level.
`default_nettype none
`include "binary_to_bcd_seven_segment_macros.svh"
module b2bss_checker
   import b2bss_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [VALUE_BITS-1:0]         req_binary_value,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [DIGIT_BITS*OUT_DIGITS-1:0] rsp_bcd_digits,
   input wire logic [SEG_BITS*OUT_DIGITS-1:0]   rsp_segment_patterns,
   input wire logic                          rsp_overflow
);

   logic                            digits_ok;
   logic [SEG_BITS*OUT_DIGITS-1:0]  segs_expected;

   // Every digit decimal, unused positions zero; segments follow from the digits
   always_comb begin
      digits_ok     = 1'b1;
      segs_expected = '0;
      for (int k = 0; k < OUT_DIGITS; k++) begin
         if (k < DIGIT_COUNT) begin
            if (rsp_bcd_digits[DIGIT_BITS*k +: DIGIT_BITS] > 4'd9) begin
               digits_ok = 1'b0;
            end
            segs_expected[SEG_BITS*k +: SEG_BITS] =
               seg_encode(rsp_bcd_digits[DIGIT_BITS*k +: DIGIT_BITS]);
         end else if (rsp_bcd_digits[DIGIT_BITS*k +: DIGIT_BITS] != '0) begin
            digits_ok = 1'b0;
         end
      end
   end

   `B2BSS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")
   `B2BSS_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bcd_digits) && $stable(rsp_overflow),
      "stalled result changed")
   `B2BSS_ASSERT(a_stall_only_when_full, clock, reset,
      req_stall |-> rsp_valid && rsp_stall, "input stalled while output side moves")
   `B2BSS_ASSERT(a_digits_decimal, clock, reset,
      rsp_valid |-> digits_ok, "result digit out of range")
   `B2BSS_ASSERT(a_segments_match, clock, reset,
      rsp_valid |-> rsp_segment_patterns == segs_expected, "segments disagree with digits")

endmodule

bind binary_to_bcd_seven_segment b2bss_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_b2bss_checker (.*);
`default_nettype wire

### bench/binary_to_bcd_seven_segment_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the binary to BCD and seven-segment converter.
module binary_to_bcd_seven_segment_test
   import b2bss_pkg::*;
();

   localparam int CLOCK_HALF   = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 160;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_COUNT  = 5;
   localparam int PRESSURE_PHASE = 4;

   // One predicted display: packed digits, segment codes and overflow
   typedef struct packed {
      logic [DIGIT_BITS*OUT_DIGITS-1:0] bcd;
      logic [SEG_BITS*OUT_DIGITS-1:0]   segments;
      logic                             overflow;
   } display_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [VALUE_BITS-1:0]            req_binary_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [DIGIT_BITS*OUT_DIGITS-1:0] rsp_bcd_digits;
   logic [SEG_BITS*OUT_DIGITS-1:0]   rsp_segment_patterns;
   logic                             rsp_overflow;

   logic [VALUE_BITS-1:0] pending_values[$];
   display_type           expected_displays[$];
   bit                    value_taken;
   bit                    hold_req;
   int unsigned           hold_left;
   int unsigned           sender_idle_pct;
   int unsigned           stall_pct;
   int unsigned           cycle_count;
   int unsigned           error_count;

   binary_to_bcd_seven_segment uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_binary_value     (req_binary_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bcd_digits       (rsp_bcd_digits),
      .rsp_segment_patterns (rsp_segment_patterns),
      .rsp_overflow         (rsp_overflow)
   );

   // Seven-segment code of one decimal digit, a in bit 6
   function automatic logic [SEG_BITS-1:0] digit_segments(input logic [DIGIT_BITS-1:0] digit);
      logic [SEG_BITS-1:0] code;
      case (digit)
         4'd0: code = 7'h7E;
         4'd1: code = 7'h30;
         4'd2: code = 7'h6D;
         4'd3: code = 7'h79;
         4'd4: code = 7'h33;
         4'd5: code = 7'h5B;
         4'd6: code = 7'h5F;
         4'd7: code = 7'h70;
         4'd8: code = 7'h7F;
         default: code = 7'h7B;
      endcase
      return code;
   endfunction

   // Decimal display of a value: digits modulo 10^DIGITS, overflow at or above that
   function automatic display_type decimal_display(input logic [VALUE_BITS-1:0] value);
      display_type            shown;
      longint unsigned        rest;
      longint unsigned        limit;
      logic [DIGIT_BITS-1:0]  digit;
      int                     k;
      shown = '0;
      limit = 1;
      for (k = 0; k < DIGIT_COUNT_DEFAULT; k++)
         limit = limit * 10;
      rest = longint'(value) & ((64'd1 << INPUT_BITS_DEFAULT) - 1);
      shown.overflow = (rest >= limit);
      rest = rest % limit;
      for (k = 0; k < OUT_DIGITS; k++) begin
         if (k < DIGIT_COUNT_DEFAULT) begin
            digit = DIGIT_BITS'(rest % 10);
            rest = rest / 10;
            shown.bcd[DIGIT_BITS*k +: DIGIT_BITS] = digit;
            shown.segments[SEG_BITS*k +: SEG_BITS] = digit_segments(digit);
         end
      end
      return shown;
   endfunction

   // Random value: full range, in range, near the overflow boundary, or small
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] value;
      case ($urandom_range(5))
         0, 1: value = $urandom;
         2: value = $urandom_range(99999999);
         3: value = $urandom_range(100000063, 99999936);
         4: value = $urandom_range(999);
         default: value = {1'($urandom_range(1)), 31'($urandom)};
      endcase
      return value;
   endfunction

   // Wait until every value has been sent and every display has come back
   task automatic wait_drained();
      while (pending_values.size() != 0 || req_valid || expected_displays.size() != 0)
         @(posedge clock);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Input driver: next value after a transaction, with random idle cycles
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || value_taken) begin
         if (pending_values.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid        <= 1'b1;
            req_binary_value <= pending_values.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: predict on input transactions, check on result transactions
   always @(posedge clock) begin
      display_type want;
      cycle_count++;
      value_taken = !reset && req_valid && !req_stall;
      if (value_taken)
         expected_displays.push_back(decimal_display(req_binary_value));
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_displays.size() == 0) begin
            error_count++;
            $display("%0t: result with no value pending: bcd %h", $time, rsp_bcd_digits);
         end else begin
            want = expected_displays.pop_front();
            if (rsp_bcd_digits !== want.bcd) begin
               error_count++;
               $display("%0t: bcd_digits expected %h actual %h",
                        $time, want.bcd, rsp_bcd_digits);
            end
            if (rsp_segment_patterns !== want.segments) begin
               error_count++;
               $display("%0t: segment_patterns expected %h actual %h",
                        $time, want.segments, rsp_segment_patterns);
            end
            if (rsp_overflow !== want.overflow) begin
               error_count++;
               $display("%0t: overflow expected %b actual %b",
                        $time, want.overflow, rsp_overflow);
            end
         end
      end
   end

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("binary_to_bcd_seven_segment_test: FAIL");
      $finish;
   end

   // Stimulus phases
   initial begin
      int p;
      int n;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_binary_value = '0;
      rsp_stall        = 1'b0;
      value_taken      = 1'b0;
      hold_req         = 1'b0;
      hold_left        = 0;
      sender_idle_pct  = 0;
      stall_pct        = 0;
      cycle_count      = 0;
      error_count      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: extremes, every digit, both sides of the overflow boundary
      pending_values.push_back(32'd0);
      pending_values.push_back(32'd1);
      pending_values.push_back(32'd9);
      pending_values.push_back(32'd10);
      pending_values.push_back(32'd12345678);
      pending_values.push_back(32'd90909090);
      pending_values.push_back(32'd87654321);
      pending_values.push_back(32'd99999998);
      pending_values.push_back(32'd99999999);
      pending_values.push_back(32'd100000000);
      pending_values.push_back(32'd100000001);
      pending_values.push_back(32'd999999999);
      pending_values.push_back(32'd1000000000);
      pending_values.push_back(32'h7FFFFFFF);
      pending_values.push_back(32'h80000000);
      pending_values.push_back(32'h55555555);
      pending_values.push_back(32'hAAAAAAAA);
      pending_values.push_back(32'hFFFFFFFE);
      pending_values.push_back(32'hFFFFFFFF);
      wait_drained();

      // Random phases with different idle and stall rates
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 61; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 61; end
            3: begin sender_idle_pct = 25; stall_pct = 25; end
            default: begin sender_idle_pct = 0; stall_pct = 0; end
         endcase
         // long receiver hold-off while the sender keeps offering values
         if (p == PRESSURE_PHASE)
            hold_req = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++)
            pending_values.push_back(random_value());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_displays.size() == 0) begin
         $display("binary_to_bcd_seven_segment_test: PASS");
      end else begin
         $display("binary_to_bcd_seven_segment_test: FAIL");
      end
      $finish;
   end

endmodule

### binary_to_bcd_seven_segment.f
+incdir+rtl
rtl/b2bss_pkg.sv
rtl/b2bss_dabble_stage.sv
rtl/b2bss_seg_stage.sv
rtl/binary_to_bcd_seven_segment.sv
rtl/b2bss_checker.sv
bench/binary_to_bcd_seven_segment_test.sv
